/* sv/websocket_client_deframer_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the deframer checker
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_CLIENT_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define WSCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wscd check failed");

// next-cycle implication, off while in reset
`define WSCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wscd check failed");

`endif

/* sv/wscd_pkg.sv */
// ---------------------------------------------------------------------------
// wscd_pkg
// Types and constants shared by the WebSocket client deframer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package wscd_pkg;

  localparam int unsigned CFG_WIDTH           = 25;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 25;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam logic [CFG_WIDTH-1:0] MAX_PAYLOAD_DEFAULT = CFG_WIDTH'(16 * 1024 * 1024);

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] OP_TEXT     = 8'd129;
  localparam logic [7:0] OP_BINARY   = 8'd130;
  localparam logic [7:0] OP_CLOSE    = 8'd136;
  localparam logic [7:0] OP_PING     = 8'd137;
  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [2:0] CRLF_RUN_END  = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_HANDSHAKE  = 3'd1,
    KIND_DATA       = 3'd2,
    KIND_EMPTY_DATA = 3'd3,
    KIND_PING       = 3'd4,
    KIND_EMPTY_PING = 3'd5,
    KIND_CLOSE      = 3'd6,
    KIND_LEN_ERR    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_CLOSE,
    CLS_PING,
    CLS_OTHER
  } opc_cls_t;

  typedef enum logic [3:0] {
    PH_HANDSHAKE,
    PH_OPCODE,
    PH_DLEN,
    PH_DEXT,
    PH_DPAY,
    PH_PLEN,
    PH_PPAY,
    PH_SLEN,
    PH_SKIP,
    PH_ERROR
  } phase_t;

  // one received byte with its decode precomputed
  typedef struct packed {
    logic [7:0] data;
    logic       is_crlf;
    opc_cls_t   cls;
    logic       is_bin;
    logic [6:0] len7;
    logic       len7_short;
    logic       len7_ext16;
    logic       byte_short;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       is_bin;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

/* sv/websocket_client_deframer_unit.sv */
// ---------------------------------------------------------------------------
// websocket_client_deframer_unit
// Client-side WebSocket deframer: handshake end detect, frame parse, payload.
//
//   channel   handshake          payload
//   -------   ----------------   --------------------------------------------
//   input     push / full        rx_byte
//   result    pop / empty        out_kind, out_byte, is_binary, last_of_frame
//   config    cfg_write          cfg_data (max payload length)
//
// One result per received byte; one byte per cycle sustained while pop is
// held. A byte is registered in the input queue; the parser decodes it into
// a result registered in the output queue. Both queues hold two words, so
// push and pop stall independently. rst is synchronous and empties both
// queues and returns the parser to waiting for the handshake end.
// ---------------------------------------------------------------------------
`default_nettype none

module websocket_client_deframer_unit #(
  parameter int unsigned COUNT_WIDTH = wscd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     rx_byte,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [2:0]                          out_kind,
  output logic [7:0]                          out_byte,
  output logic                                is_binary,
  output logic                                last_of_frame,
  input  wire logic                           cfg_write,
  input  wire logic [wscd_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int unsigned CFGW = wscd_pkg::CFG_WIDTH;
  localparam logic [CFGW-1:0] CFG_CLAMP =
    (COUNT_WIDTH >= CFGW) ? {CFGW{1'b1}} : CFGW'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [CFGW-1:0] LIMIT_RESET =
    (wscd_pkg::MAX_PAYLOAD_DEFAULT > CFG_CLAMP) ? CFG_CLAMP : wscd_pkg::MAX_PAYLOAD_DEFAULT;

  logic              limit;
  logic [CFGW-1:0]   limit_len;
  logic              item_valid;
  wscd_pkg::item_t   item;
  logic              item_pop;
  logic              res_valid;
  logic              out_full;
  wscd_pkg::result_t res;
  wscd_pkg::result_t out_res;

  // hold the limit already clamped to what the counter can represent
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_len <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit_len <= (cfg_data > CFG_CLAMP) ? CFG_CLAMP : cfg_data;
    end
  end

  assign limit = 1'b0;

  wscd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  wscd_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst || limit),
    .limit      (limit_len),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_ready  (!out_full),
    .res_valid  (res_valid),
    .res        (res)
  );

  wscd_fifo #(
    .WIDTH ($bits(wscd_pkg::result_t)),
    .DEPTH (wscd_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_kind      = out_res.kind;
  assign out_byte      = out_res.data;
  assign is_binary     = out_res.is_bin;
  assign last_of_frame = out_res.last;

endmodule

`default_nettype wire

/* sv/wscd_fifo.sv */
// ---------------------------------------------------------------------------
// wscd_fifo
// Small synchronous word queue with registered storage.
// ---------------------------------------------------------------------------
`default_nettype none

module wscd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = wscd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/wscd_front.sv */
// ---------------------------------------------------------------------------
// wscd_front
// Accepts received bytes, decodes them and queues them for the parser.
// ---------------------------------------------------------------------------
`default_nettype none

module wscd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [7:0]      rx_byte,
  output logic                 full,
  output logic                 item_valid,
  output wscd_pkg::item_t      item,
  input  wire logic            item_pop
);

  wscd_pkg::item_t cls_item;
  logic            q_empty;

  always_comb begin
    cls_item            = '0;
    cls_item.data       = rx_byte;
    cls_item.is_crlf    = rx_byte inside {wscd_pkg::CHAR_CR, wscd_pkg::CHAR_LF};
    cls_item.is_bin     = (rx_byte == wscd_pkg::OP_BINARY);
    cls_item.len7       = rx_byte[6:0];
    cls_item.len7_short = rx_byte[6:0] inside {[7'd0 : wscd_pkg::LEN_SHORT_MAX]};
    cls_item.len7_ext16 = (rx_byte[6:0] == wscd_pkg::LEN_EXT16);
    cls_item.byte_short = rx_byte inside {[8'd0 : {1'b0, wscd_pkg::LEN_SHORT_MAX}]};
    case (rx_byte)
      wscd_pkg::OP_TEXT,
      wscd_pkg::OP_BINARY: cls_item.cls = wscd_pkg::CLS_DATA;
      wscd_pkg::OP_CLOSE:  cls_item.cls = wscd_pkg::CLS_CLOSE;
      wscd_pkg::OP_PING:   cls_item.cls = wscd_pkg::CLS_PING;
      default:             cls_item.cls = wscd_pkg::CLS_OTHER;
    endcase
  end

  wscd_fifo #(
    .WIDTH ($bits(wscd_pkg::item_t)),
    .DEPTH (wscd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

`default_nettype wire

/* sv/wscd_parser.sv */
// ---------------------------------------------------------------------------
// wscd_parser
// Frame parser: walks the handshake and frame phases, one result per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module wscd_parser #(
  parameter int unsigned COUNT_WIDTH = wscd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [wscd_pkg::CFG_WIDTH-1:0]  limit,
  input  wire logic                            item_valid,
  input  wire wscd_pkg::item_t                 item,
  output logic                                 item_pop,
  input  wire logic                            res_ready,
  output logic                                 res_valid,
  output wscd_pkg::result_t                    res
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned CMPW = (CW > wscd_pkg::CFG_WIDTH) ? CW : wscd_pkg::CFG_WIDTH;

  wscd_pkg::phase_t phase, phase_next;
  logic [2:0]       crlf_run, crlf_next;
  logic             is_bin, bin_next;
  logic [CW-1:0]    accum, accum_next;
  logic             ovf, ovf_next;
  logic [3:0]       bytes_left, left_next;
  logic [CW-1:0]    payload_left, pay_next;

  logic             fire;
  logic [CW+7:0]    shifted;
  logic [3:0]       ext_left;
  logic [CW-1:0]    len_accum;
  logic             len_ovf;
  logic             too_long;
  logic             len_zero;
  logic             finish;
  logic [CW-1:0]    pay_dec;
  logic [2:0]       crlf_inc;

  assign fire      = item_valid && res_ready;
  assign item_pop  = fire;
  assign res_valid = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wscd_pkg::PH_HANDSHAKE;
      crlf_run     <= '0;
      is_bin       <= 1'b0;
      accum        <= '0;
      ovf          <= 1'b0;
      bytes_left   <= '0;
      payload_left <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      crlf_run     <= crlf_next;
      is_bin       <= bin_next;
      accum        <= accum_next;
      ovf          <= ovf_next;
      bytes_left   <= left_next;
      payload_left <= pay_next;
    end
  end

  always_comb begin
    phase_next = phase;
    crlf_next  = crlf_run;
    bin_next   = is_bin;
    accum_next = accum;
    ovf_next   = ovf;
    left_next  = bytes_left;
    pay_next   = payload_left;
    res        = '{kind: wscd_pkg::KIND_NONE, data: 8'd0, is_bin: 1'b0, last: 1'b0};
    finish     = 1'b0;

    // extended length: shift in the byte, remember any bits pushed off the top
    shifted  = {accum, item.data};
    ext_left = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
    if (phase == wscd_pkg::PH_DLEN) begin
      len_accum = CW'(item.len7);
      len_ovf   = 1'b0;
    end else begin
      len_accum = shifted[CW-1:0];
      len_ovf   = ovf | (|shifted[CW+7:CW]);
    end
    too_long = len_ovf || (CMPW'(len_accum) > CMPW'(limit));
    len_zero = !len_ovf && (len_accum == '0);
    pay_dec  = (payload_left != '0) ? payload_left - 1'b1 : payload_left;
    crlf_inc = crlf_run + 1'b1;

    case (phase)
      wscd_pkg::PH_HANDSHAKE: begin
        if (item.is_crlf) begin
          if (crlf_inc >= wscd_pkg::CRLF_RUN_END) begin
            crlf_next  = '0;
            phase_next = wscd_pkg::PH_OPCODE;
            res        = '{kind: wscd_pkg::KIND_HANDSHAKE, data: 8'd0, is_bin: 1'b0,
                           last: 1'b1};
          end else begin
            crlf_next = crlf_inc;
          end
        end else begin
          crlf_next = '0;
        end
      end
      wscd_pkg::PH_OPCODE: begin
        bin_next   = item.is_bin;
        accum_next = '0;
        ovf_next   = 1'b0;
        case (item.cls)
          wscd_pkg::CLS_DATA:  phase_next = wscd_pkg::PH_DLEN;
          wscd_pkg::CLS_CLOSE: begin
            bin_next   = 1'b0;
            crlf_next  = '0;
            phase_next = wscd_pkg::PH_HANDSHAKE;
            res        = '{kind: wscd_pkg::KIND_CLOSE, data: 8'd0, is_bin: 1'b0, last: 1'b1};
          end
          wscd_pkg::CLS_PING:  phase_next = wscd_pkg::PH_PLEN;
          default:             phase_next = wscd_pkg::PH_SLEN;
        endcase
      end
      wscd_pkg::PH_DLEN: begin
        if (item.len7_short) begin
          finish = 1'b1;
        end else begin
          accum_next = '0;
          ovf_next   = 1'b0;
          left_next  = item.len7_ext16 ? wscd_pkg::EXT16_BYTES : wscd_pkg::EXT64_BYTES;
          phase_next = wscd_pkg::PH_DEXT;
        end
      end
      wscd_pkg::PH_DEXT: begin
        accum_next = len_accum;
        ovf_next   = len_ovf;
        left_next  = ext_left;
        finish     = (ext_left == '0);
      end
      wscd_pkg::PH_DPAY,
      wscd_pkg::PH_PPAY: begin
        pay_next = pay_dec;
        if (phase == wscd_pkg::PH_DPAY) begin
          res.kind   = wscd_pkg::KIND_DATA;
          res.is_bin = is_bin;
        end else begin
          res.kind   = wscd_pkg::KIND_PING;
        end
        res.data = item.data;
        if (pay_dec == '0) begin
          res.last   = 1'b1;
          phase_next = wscd_pkg::PH_OPCODE;
          bin_next   = 1'b0;
        end
      end
      wscd_pkg::PH_PLEN: begin
        if (!item.byte_short || item.data == 8'd0) begin
          phase_next = wscd_pkg::PH_OPCODE;
          bin_next   = 1'b0;
          res        = '{kind: wscd_pkg::KIND_EMPTY_PING, data: 8'd0, is_bin: 1'b0,
                         last: 1'b1};
        end else begin
          pay_next   = CW'(item.data);
          phase_next = wscd_pkg::PH_PPAY;
        end
      end
      wscd_pkg::PH_SLEN: begin
        if (!item.byte_short || item.data == 8'd0) begin
          phase_next = wscd_pkg::PH_OPCODE;
          bin_next   = 1'b0;
        end else begin
          pay_next   = CW'(item.data);
          phase_next = wscd_pkg::PH_SKIP;
        end
      end
      wscd_pkg::PH_SKIP: begin
        pay_next = pay_dec;
        if (pay_dec == '0) begin
          phase_next = wscd_pkg::PH_OPCODE;
          bin_next   = 1'b0;
        end
      end
      default: phase_next = wscd_pkg::PH_ERROR;
    endcase

    // length complete: check it against the limit, then enter payload (or flag an empty frame or a length error)
    if (finish) begin
      accum_next = len_accum;
      ovf_next   = len_ovf;
      if (too_long) begin
        phase_next = wscd_pkg::PH_ERROR;
        res        = '{kind: wscd_pkg::KIND_LEN_ERR, data: 8'd0, is_bin: 1'b0, last: 1'b1};
      end else if (len_zero) begin
        phase_next = wscd_pkg::PH_OPCODE;
        bin_next   = 1'b0;
        res        = '{kind: wscd_pkg::KIND_EMPTY_DATA, data: 8'd0, is_bin: is_bin,
                       last: 1'b1};
      end else begin
        pay_next   = len_accum;
        phase_next = wscd_pkg::PH_DPAY;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wscd_checker.sv */
// ---------------------------------------------------------------------------
// wscd_checker
// Port-level checks on the deframer result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "websocket_client_deframer_unit_assert.svh"

module wscd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       is_binary,
  input wire logic       last_of_frame
);

  logic has_byte;
  logic single_event;
  logic data_kind;

  assign has_byte = (out_kind == wscd_pkg::KIND_DATA) || (out_kind == wscd_pkg::KIND_PING);
  assign single_event = (out_kind == wscd_pkg::KIND_HANDSHAKE)
                     || (out_kind == wscd_pkg::KIND_EMPTY_DATA)
                     || (out_kind == wscd_pkg::KIND_EMPTY_PING)
                     || (out_kind == wscd_pkg::KIND_CLOSE)
                     || (out_kind == wscd_pkg::KIND_LEN_ERR);
  assign data_kind = (out_kind == wscd_pkg::KIND_DATA)
                  || (out_kind == wscd_pkg::KIND_EMPTY_DATA);

  `WSCD_ASSERT_NOW(a_byte_only_payload, clk, rst, !empty && !has_byte, out_byte == 8'd0)
  `WSCD_ASSERT_NOW(a_binary_data_only, clk, rst, !empty && is_binary, data_kind)
  `WSCD_ASSERT_NOW(a_event_is_last, clk, rst, !empty && single_event, last_of_frame)
  `WSCD_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(out_kind) && $stable(out_byte))

endmodule

bind websocket_client_deframer_unit wscd_checker u_wscd_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .out_kind      (out_kind),
  .out_byte      (out_byte),
  .is_binary     (is_binary),
  .last_of_frame (last_of_frame)
);

`default_nettype wire
